### rtl/core/sptq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sptq_pkg;

   // queue geometry
   localparam int PRIORITIES = 4;
   localparam int CAPACITY   = 256;
   localparam int TAG_BITS   = 16;

   // derived widths
   localparam int PRIO_BITS  = $clog2(PRIORITIES);
   localparam int PTR_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int ADDR_BITS  = PRIO_BITS + PTR_BITS;
   localparam int STORE_DEPTH = PRIORITIES * CAPACITY;

   // fixed field widths
   localparam int OPC_BITS    = 2;
   localparam int LEVEL_BITS  = 2;
   localparam int LIMIT_BITS  = 9;
   localparam int TOTAL_BITS  = 9;
   localparam int INLINE_BITS = 32;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(256);

   // command codes
   typedef enum logic [OPC_BITS-1:0] {
      OP_SUBMIT   = 2'd0,
      OP_POP      = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

endpackage

`default_nettype wire

### rtl/core/sptq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sptq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/strict_priority_task_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Strict-priority task queue with a bounded slot pool.
// Command channel: a word (opcode, priority level, task tag) is taken at a
// rising edge where start is high and busy is low. busy stays low, so one
// command can be issued every cycle.
// Result channel: each command yields exactly one result word, shown on the
// rsp_ ports for one cycle with rsp_strobe high, in the cycle right after the
// command was taken. The receiver cannot stall; the result is
// gone after that cycle.
// Rate: one command per cycle. Tags live in one 1024 x 16 RAM with registered
// read; the pop read is issued at the command edge and its data is the popped
// tag of the next cycle. Heads, tails and counts sit in flops, so back to back
// commands see updated pointers without any interlock.
// Configuration: csr_write_enable loads the slot limit (9 bits); write only
// when no result is pending.
// Reset (synchronous, active high): all queues empty, counts zero, slot limit
// 256. The tag RAM is not cleared; only written entries are ever read.

module strict_priority_task_queue
   import sptq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [OPC_BITS-1:0]    req_opcode,
   input  wire logic [LEVEL_BITS-1:0]  req_priority_level,
   input  wire logic [TAG_BITS-1:0]    req_task_tag,
   // result channel
   output logic                        rsp_strobe,
   output logic                        rsp_submit_accepted,
   output logic                        rsp_pop_valid,
   output logic [TAG_BITS-1:0]         rsp_popped_tag,
   output logic [LEVEL_BITS-1:0]       rsp_popped_priority,
   output logic [TOTAL_BITS-1:0]       rsp_queued_total,
   output logic [TOTAL_BITS-1:0]       rsp_outstanding_total,
   output logic                        rsp_idle_flag,
   output logic [INLINE_BITS-1:0]      rsp_inline_total,
   // configuration
   input  wire logic                   csr_write_enable,
   input  wire logic [LIMIT_BITS-1:0]  csr_write_data
);

   logic [PTR_BITS-1:0]    heads_ff  [PRIORITIES];
   logic [PTR_BITS-1:0]    heads_in  [PRIORITIES];
   logic [PTR_BITS-1:0]    tails_ff  [PRIORITIES];
   logic [PTR_BITS-1:0]    tails_in  [PRIORITIES];
   logic [CNT_BITS-1:0]    counts_ff [PRIORITIES];
   logic [CNT_BITS-1:0]    counts_in [PRIORITIES];
   logic [CNT_BITS-1:0]    waiting_ff, waiting_in;
   logic [CNT_BITS-1:0]    slots_ff, slots_in;
   logic [INLINE_BITS-1:0] refused_ff, refused_in;
   logic [LIMIT_BITS-1:0]  limit_ff, limit_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   accepted_ff, accepted_in;
   logic                   pop_valid_ff, pop_valid_in;
   logic [PRIO_BITS-1:0]   pop_prio_ff, pop_prio_in;

   opcode_type             opcode;
   logic                   take;
   logic [PRIO_BITS-1:0]   sub_prio;
   logic [PRIO_BITS-1:0]   pick_prio;
   logic                   pick_found;
   logic [PRIO_BITS-1:0]   sel_prio;
   logic [PTR_BITS-1:0]    sel_head, sel_tail;
   logic [CNT_BITS-1:0]    sel_count;
   logic                   sub_refused;
   logic                   do_write, do_read;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
   logic [TAG_BITS-1:0]    rd_tag;

   assign busy   = 1'b0;
   assign take   = start && !busy;
   assign opcode = opcode_type'(req_opcode);

   // clamp the submit priority to the lowest queue
   always_comb begin
      if (int'(req_priority_level) >= PRIORITIES) begin
         sub_prio = PRIO_BITS'(PRIORITIES - 1);
      end else begin
         sub_prio = PRIO_BITS'(req_priority_level);
      end
   end

   // fixed priority encoder, queue 0 wins
   always_comb begin
      pick_prio  = '0;
      pick_found = 1'b0;
      for (int i = PRIORITIES - 1; i >= 0; i--) begin
         if (counts_ff[i] != '0) begin
            pick_prio  = PRIO_BITS'(i);
            pick_found = 1'b1;
         end
      end
   end

   // one queue is touched per command
   assign sel_prio  = (opcode == OP_SUBMIT) ? sub_prio : pick_prio;
   assign sel_head  = heads_ff[sel_prio];
   assign sel_tail  = tails_ff[sel_prio];
   assign sel_count = counts_ff[sel_prio];

   assign sub_refused = (int'(slots_ff) >= int'(limit_ff))
                     || (int'(slots_ff) >= CAPACITY)
                     || (int'(sel_count) >= CAPACITY)
                     || (int'(waiting_ff) >= CAPACITY);

   assign do_write = take && (opcode == OP_SUBMIT) && !sub_refused;
   assign do_read  = take && (opcode == OP_POP) && pick_found;
   assign wr_addr  = {sel_prio, sel_tail};
   assign rd_addr  = {sel_prio, sel_head};

   // next state of pointers and counters
   always_comb begin
      heads_in      = heads_ff;
      tails_in      = tails_ff;
      counts_in     = counts_ff;
      waiting_in    = waiting_ff;
      slots_in      = slots_ff;
      refused_in    = refused_ff;
      accepted_in   = 1'b0;
      pop_valid_in  = 1'b0;
      pop_prio_in   = '0;
      rsp_strobe_in = take;
      if (take) begin
         case (opcode)
            OP_SUBMIT: begin
               if (sub_refused) begin
                  refused_in = refused_ff + 1'b1;
               end else begin
                  accepted_in = 1'b1;
                  if (int'(sel_tail) == CAPACITY - 1) begin
                     tails_in[sel_prio] = '0;
                  end else begin
                     tails_in[sel_prio] = sel_tail + 1'b1;
                  end
                  counts_in[sel_prio] = sel_count + 1'b1;
                  waiting_in          = waiting_ff + 1'b1;
                  slots_in            = slots_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (pick_found) begin
                  pop_valid_in = 1'b1;
                  pop_prio_in  = sel_prio;
                  if (int'(sel_head) == CAPACITY - 1) begin
                     heads_in[sel_prio] = '0;
                  end else begin
                     heads_in[sel_prio] = sel_head + 1'b1;
                  end
                  counts_in[sel_prio] = sel_count - 1'b1;
                  if (waiting_ff != '0) begin
                     waiting_in = waiting_ff - 1'b1;
                  end
               end
            end
            OP_COMPLETE: begin
               if (slots_ff != '0) begin
                  slots_in = slots_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // slot limit register
   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PRIORITIES; i++) begin
            heads_ff[i]  <= '0;
            tails_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
         waiting_ff    <= '0;
         slots_ff      <= '0;
         refused_ff    <= '0;
         limit_ff      <= LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
         accepted_ff   <= 1'b0;
         pop_valid_ff  <= 1'b0;
         pop_prio_ff   <= '0;
      end else begin
         heads_ff      <= heads_in;
         tails_ff      <= tails_in;
         counts_ff     <= counts_in;
         waiting_ff    <= waiting_in;
         slots_ff      <= slots_in;
         refused_ff    <= refused_in;
         limit_ff      <= limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
         accepted_ff   <= accepted_in;
         pop_valid_ff  <= pop_valid_in;
         pop_prio_ff   <= pop_prio_in;
      end
   end

   // tag store, one region per priority
   sptq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (req_task_tag),
      .rd_en   (do_read),
      .rd_addr (rd_addr),
      .rd_data (rd_tag)
   );

   // result word
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_submit_accepted   = accepted_ff;
   assign rsp_pop_valid         = pop_valid_ff;
   assign rsp_popped_tag        = pop_valid_ff ? rd_tag : '0;
   assign rsp_popped_priority   = LEVEL_BITS'(pop_prio_ff);
   assign rsp_queued_total      = TOTAL_BITS'(waiting_ff);
   assign rsp_outstanding_total = TOTAL_BITS'(slots_ff);
   assign rsp_idle_flag         = (slots_ff == '0);
   assign rsp_inline_total      = refused_ff;

   // every taken command gives a result word in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_strobe)
      else $error("command without result word");

   // a popped task leaves the waiting count one lower
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_pop_valid |->
         rsp_queued_total == TOTAL_BITS'($past(waiting_ff) - 1'b1))
      else $error("pop did not lower queued total");

   // an accepted submit takes exactly one slot
   a_submit_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_submit_accepted |->
         rsp_outstanding_total == TOTAL_BITS'($past(slots_ff) + 1'b1))
      else $error("submit did not take a slot");

   // a refused submit bumps the inline count and leaves the queues alone
   a_refuse_inline: assert property (@(posedge clock) disable iff (reset)
      take && opcode == OP_SUBMIT && sub_refused |=>
         refused_ff == $past(refused_ff) + 1'b1 && waiting_ff == $past(waiting_ff))
      else $error("refused submit handled wrongly");

   // the ram is never written and read by the same command
   a_one_port_use: assert property (@(posedge clock) disable iff (reset)
      !(do_write && do_read))
      else $error("tag ram written and read together");

endmodule

`default_nettype wire
